/* rtl/aarm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared types, constants and the arctangent table for the rotation block.
// ----------------------------------------------------------------------------
package aarm_pkg;

  localparam int DataWidth   = 16;
  localparam int FracBits    = DataWidth - 2;
  localparam int CordicSteps = 16;
  localparam int CordicW     = 34;
  localparam int ZW          = 34;
  localparam int CordicFrac  = 30;
  localparam int RndShift    = CordicFrac - FracBits;
  localparam int IdxW        = $clog2(CordicSteps);

  localparam logic [1:0] ModeAxis = 2'd0;
  localparam logic [1:0] ModeX    = 2'd1;
  localparam logic [1:0] ModeY    = 2'd2;
  localparam logic [1:0] ModeZ    = 2'd3;

  localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;

  typedef logic signed [DataWidth-1:0] data_t;

  typedef struct packed {
    logic [1:0] mode;
    data_t      axis_x;
    data_t      axis_y;
    data_t      axis_z;
    logic signed [15:0] angle;
  } req_t;

  typedef struct packed {
    data_t row1_col1;
    data_t row1_col2;
    data_t row1_col3;
    data_t row2_col1;
    data_t row2_col2;
    data_t row2_col3;
    data_t row3_col1;
    data_t row3_col2;
    data_t row3_col3;
  } mat_t;

  typedef struct packed {
    logic [1:0] mode;
    data_t      axis_x;
    data_t      axis_y;
    data_t      axis_z;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0: r = 34'sd536870912;  5'd1: r = 34'sd316933406;
      5'd2: r = 34'sd167458907;  5'd3: r = 34'sd85004756;
      5'd4: r = 34'sd42667331;   5'd5: r = 34'sd21354465;
      5'd6: r = 34'sd10679838;   5'd7: r = 34'sd5340245;
      5'd8: r = 34'sd2670163;    5'd9: r = 34'sd1335087;
      5'd10: r = 34'sd667544;    5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;    5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;     5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;     5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;       5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;       5'd23: r = 34'sd81;
      5'd24: r = 34'sd41;        5'd25: r = 34'sd20;
      5'd26: r = 34'sd10;        5'd27: r = 34'sd5;
      5'd28: r = 34'sd3;         5'd29: r = 34'sd1;
      5'd30: r = 34'sd1;         default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/aarm_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_req_if / aarm_mat_if
// Valid/ready channels for request beats and matrix beats.
// ----------------------------------------------------------------------------
interface aarm_req_if;
  logic valid;
  logic ready;
  aarm_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface aarm_mat_if;
  logic valid;
  logic ready;
  aarm_pkg::mat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/axis_angle_rotation_matrix.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Rotation matrix from axis and angle.
//
// Usage: req_i takes one beat per cycle while ready is high (mode, Q1.14
// axis, binary angle); mat_o gives one beat of nine Q1.14 entries per
// request, in order. Path: fold register, 16 CORDIC stages, sin/cos
// rounding, then three matrix stages; the CORDIC is fully pipelined.
// Throughput: one beat per cycle, as long as the output does not stall.
// The whole pipe advances as one when the output register is empty or is
// taken; when the receiver stalls with a full output, the pipe holds and
// req_i.ready drops, so nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  aarm_req_if.sink         req_i,
  aarm_mat_if.source       mat_o
);
  logic en, cv;
  aarm_pkg::data_t s, c;
  aarm_pkg::side_t sd_in, sd;

  assign en = !mat_o.valid || mat_o.ready;
  assign req_i.ready = en;
  assign sd_in = '{mode: req_i.data.mode, axis_x: req_i.data.axis_x,
                   axis_y: req_i.data.axis_y, axis_z: req_i.data.axis_z};

  aarm_cordic u_cordic (
    .clk_i, .rst_ni, .en_i(en), .valid_i(req_i.valid),
    .angle_i(req_i.data.angle), .side_i(sd_in),
    .valid_o(cv), .sin_o(s), .cos_o(c), .side_o(sd)
  );

  aarm_matrix u_matrix (
    .clk_i, .rst_ni, .en_i(en), .valid_i(cv), .sin_i(s), .cos_i(c),
    .side_i(sd), .valid_o(mat_o.valid), .mat_o(mat_o.data)
  );
endmodule
`default_nettype wire

/* rtl/aarm_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_cordic
// Pipelined rotation CORDIC, one micro-rotation per stage, with quadrant fold,
// rounding and saturation of sine and cosine. Side data rides along.
// ----------------------------------------------------------------------------
module aarm_cordic (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic signed [15:0]   angle_i,
  input  wire aarm_pkg::side_t      side_i,
  output logic                      valid_o,
  output aarm_pkg::data_t           sin_o,
  output aarm_pkg::data_t           cos_o,
  output aarm_pkg::side_t           side_o
);
  localparam int N  = aarm_pkg::CordicSteps;
  localparam int W  = aarm_pkg::CordicW;
  localparam int DW = aarm_pkg::DataWidth;

  logic                 v_q   [N+1];
  logic signed [W-1:0]  x_q   [N+1];
  logic signed [W-1:0]  y_q   [N+1];
  logic signed [aarm_pkg::ZW-1:0] z_q [N+1];
  logic                 neg_q [N+1];
  aarm_pkg::side_t      sd_q  [N+1];

  logic signed [15:0] a_fold;
  logic               neg_d;
  always_comb begin
    neg_d  = 1'b0;
    a_fold = angle_i;
    if (angle_i > 16'sd16384) begin
      a_fold = angle_i - 16'sh8000;
      neg_d  = 1'b1;
    end else if (angle_i < -16'sd16384) begin
      a_fold = angle_i + 16'sh8000;
      neg_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q[0] <= 1'b0;
    else if (en_i) v_q[0] <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= aarm_pkg::CordicGain;
      y_q[0]   <= '0;
      z_q[0]   <= {{(aarm_pkg::ZW-32){a_fold[15]}}, a_fold, 16'h0000};
      neg_q[0] <= neg_d;
      sd_q[0]  <= side_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [4:0] K = 5'(i % 32);
    logic signed [W-1:0] dx, dy;
    assign dx = y_q[i] >>> K;
    assign dy = x_q[i] >>> K;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[i+1] <= 1'b0;
      else if (en_i) v_q[i+1] <= v_q[i];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][aarm_pkg::ZW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - aarm_pkg::atan_lut(K);
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + aarm_pkg::atan_lut(K);
        end
        neg_q[i+1] <= neg_q[i];
        sd_q[i+1]  <= sd_q[i];
      end
    end
  end

  function automatic aarm_pkg::data_t fin(input logic signed [W-1:0] v, input logic ng);
    logic signed [W-1:0] r;
    logic signed [W-1:0] one;
    one = W'(1) <<< aarm_pkg::FracBits;
    r = (v + (W'(1) <<< (aarm_pkg::RndShift - 1))) >>> aarm_pkg::RndShift;
    if (r > one) r = one;
    else if (r < -one) r = -one;
    if (ng) r = -r;
    return DW'(r);
  endfunction

  logic            vo_q;
  aarm_pkg::data_t s_q, c_q;
  aarm_pkg::side_t so_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (en_i) vo_q <= v_q[N];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q  <= fin(y_q[N], neg_q[N]);
      c_q  <= fin(x_q[N], neg_q[N]);
      so_q <= sd_q[N];
    end
  end
  assign valid_o = vo_q;
  assign sin_o   = s_q;
  assign cos_o   = c_q;
  assign side_o  = so_q;

  property p_fold;
    @(posedge clk_i) disable iff (!rst_ni)
      en_i && valid_i |=> (z_q[0] <= 34'sh0_4000_0000 && z_q[0] >= -34'sh0_4000_0000);
  endproperty
  a_fold_rng: assert property (p_fold) else $error("angle fold out of range");
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q |-> (s_q <= 16'sd16384 && s_q >= -16'sd16384 &&
              c_q <= 16'sd16384 && c_q >= -16'sd16384))
    else $error("sin/cos out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(vo_q) && $stable(s_q))
    else $error("cordic moved during stall");
endmodule
`default_nettype wire

/* rtl/aarm_matrix.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_matrix
// Three-stage Rodrigues datapath: scaled axis, products, round, saturate and select layout.
// ----------------------------------------------------------------------------
module aarm_matrix (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire aarm_pkg::data_t sin_i,
  input  wire aarm_pkg::data_t cos_i,
  input  wire aarm_pkg::side_t side_i,
  output logic                 valid_o,
  output aarm_pkg::mat_t       mat_o
);
  localparam int DW = aarm_pkg::DataWidth;
  localparam int F  = aarm_pkg::FracBits;
  localparam int PW = 2 * DW + 4;
  localparam logic signed [PW-1:0] One  = PW'(1) <<< F;
  localparam logic signed [PW-1:0] Half = PW'(1) <<< (F - 1);

  function automatic logic signed [PW-1:0] satr(input logic signed [PW-1:0] v,
                                                input logic signed [PW-1:0] lim);
    logic signed [PW-1:0] r;
    r = (v + Half) >>> F;
    if (r > lim) r = lim;
    else if (r < -lim) r = -lim;
    return r;
  endfunction

  // stage 1: t*axis
  logic v1_q, v2_q, v3_q;
  logic signed [DW+1:0] ax_q, ay_q, az_q;
  aarm_pkg::data_t s1_q, c1_q;
  aarm_pkg::side_t sd1_q;
  logic signed [PW-1:0] t;
  assign t = One - PW'(cos_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i; v2_q <= v1_q; v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q  <= (DW+2)'(satr(t * PW'(side_i.axis_x), 2 * One));
      ay_q  <= (DW+2)'(satr(t * PW'(side_i.axis_y), 2 * One));
      az_q  <= (DW+2)'(satr(t * PW'(side_i.axis_z), 2 * One));
      s1_q  <= sin_i;
      c1_q  <= cos_i;
      sd1_q <= side_i;
    end
  end

  // stage 2: products
  logic signed [PW-1:0] p_q [9];
  logic signed [PW-1:0] xs, ys, zs, cc, xx, yy, zz;
  aarm_pkg::data_t s2_q, c2_q;
  logic [1:0] m2_q;
  assign xx = PW'(sd1_q.axis_x);
  assign yy = PW'(sd1_q.axis_y);
  assign zz = PW'(sd1_q.axis_z);
  assign xs = xx * PW'(s1_q);
  assign ys = yy * PW'(s1_q);
  assign zs = zz * PW'(s1_q);
  assign cc = PW'(c1_q) <<< F;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= PW'(ax_q) * xx + cc;
      p_q[1] <= PW'(ax_q) * yy + zs;
      p_q[2] <= PW'(ax_q) * zz - ys;
      p_q[3] <= PW'(ay_q) * xx - zs;
      p_q[4] <= PW'(ay_q) * yy + cc;
      p_q[5] <= PW'(ay_q) * zz + xs;
      p_q[6] <= PW'(az_q) * xx + ys;
      p_q[7] <= PW'(az_q) * yy - xs;
      p_q[8] <= PW'(az_q) * zz + cc;
      s2_q   <= s1_q;
      c2_q   <= c1_q;
      m2_q   <= sd1_q.mode;
    end
  end

  // stage 3: round, saturate and select layout
  aarm_pkg::mat_t m_d, m_q;
  aarm_pkg::data_t e [9];
  aarm_pkg::data_t one16, ns;
  assign one16 = DW'(One);
  assign ns = -s2_q;
  for (genvar k = 0; k < 9; k++) begin : g_e
    assign e[k] = DW'(satr(p_q[k], One));
  end

  always_comb begin
    m_d = '0;
    case (m2_q)
      aarm_pkg::ModeAxis: m_d = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
      aarm_pkg::ModeX: begin
        m_d.row1_col1 = one16;
        m_d.row2_col2 = c2_q; m_d.row2_col3 = s2_q;
        m_d.row3_col2 = ns;   m_d.row3_col3 = c2_q;
      end
      aarm_pkg::ModeY: begin
        m_d.row1_col1 = c2_q; m_d.row1_col3 = ns;
        m_d.row2_col2 = one16;
        m_d.row3_col1 = s2_q; m_d.row3_col3 = c2_q;
      end
      default: begin
        m_d.row1_col1 = c2_q; m_d.row1_col2 = s2_q;
        m_d.row2_col1 = ns;   m_d.row2_col2 = c2_q;
        m_d.row3_col3 = one16;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) m_q <= m_d;
  end
  assign valid_o = v3_q;
  assign mat_o   = m_q;

  a_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && v2_q && m2_q == aarm_pkg::ModeX |=> m_q.row1_col1 == one16)
    else $error("fixed axis diagonal wrong");
  a_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> m_q.row2_col2 <= 16'sd16384 && m_q.row2_col2 >= -16'sd16384)
    else $error("entry out of range");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(v3_q) && $stable(m_q))
    else $error("matrix moved during stall");
endmodule
`default_nettype wire
